/* design/modinv_pkg.sv */
// ----------------------------------------------------------------------------
// modinv_pkg: shared types for the modular inverse core
// Sequencer states, datapath operation codes and the datapath status word.
// ----------------------------------------------------------------------------
package modinv_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP,
    ST_DOWN,
    ST_SWAP,
    ST_FINAL
  } fsm_state_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,
    OP_UP,
    OP_DOWN,
    OP_SWAP
  } dp_op_t;

  typedef struct packed {
    logic u_zero;     // divisor is zero: Euclid loop is finished
    logic d_above_v;  // shifted divisor exceeds the running remainder
    logic k_zero;     // shift count is zero
    logic k_one;      // shift count is one
  } dp_status_t;

endpackage

/* design/modular_inverse_core.sv */
// ----------------------------------------------------------------------------
// modular_inverse_core: modular inverse by the extended Euclidean algorithm
// Operation: the word is loaded, then each Euclid step aligns the divisor up,
//   takes the quotient bits on the way back down and swaps remainder and
//   divisor; once the divisor is zero the coefficient is reduced, and the
//   result word strobes in the cycle after the reduce cycle.
// Throughput: one word at a time; busy is high from accept until the reduce
//   cycle ends, and a new word may start in the strobe cycle.
// Reset: synchronous active-low rst_n clears the sequencer and the strobe
//   and sets the modulus to 2. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module modular_inverse_core #(
  parameter int WIDTH = 31
) (
  input  logic             clk,
  input  logic             rst_n,
  // configuration
  input  logic             cfg_write_en,
  input  logic [WIDTH-1:0] cfg_modulus,
  // input word
  input  logic             start,
  output logic             busy,
  input  logic [WIDTH-1:0] in_value,
  // result word
  output logic             out_strobe,
  output logic [WIDTH-1:0] out_inverse,
  output logic             out_invertible
);
  import modinv_pkg::*;

  fsm_state_t       state_r, state_nxt;
  dp_op_t           op;
  dp_status_t       status;
  logic [WIDTH-1:0] modulus_r;
  logic [WIDTH-1:0] fix_inverse;
  logic             fix_ok;
  logic             strobe_r;
  logic [WIDTH-1:0] inverse_r;
  logic             invertible_r;

  // Modulus register; the user must write it only while idle; the core does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= WIDTH'(2);
    end else if (cfg_write_en) begin
      modulus_r <= cfg_modulus;
    end
  end

  modinv_datapath #(
    .WIDTH (WIDTH)
  ) u_datapath (
    .clk         (clk),
    .op          (op),
    .in_value    (in_value),
    .modulus     (modulus_r),
    .status      (status),
    .fix_inverse (fix_inverse),
    .fix_ok      (fix_ok)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer: each Euclid step aligns the divisor up, walks it back down
  // taking one quotient bit per cycle, then swaps remainder and divisor.
  always_comb begin
    state_nxt = state_r;
    op        = OP_HOLD;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          op        = OP_LOAD;
          state_nxt = ST_UP;
        end
      end
      ST_UP: begin
        if (status.u_zero) begin
          // divisor exhausted: gcd and coefficient are in place
          state_nxt = ST_FINAL;
        end else if (status.d_above_v) begin
          // quotient is zero when no shift was needed: swap at once
          state_nxt = status.k_zero ? ST_SWAP : ST_DOWN;
        end else begin
          op = OP_UP;
        end
      end
      ST_DOWN: begin
        op = OP_DOWN;
        if (status.k_one) begin
          state_nxt = ST_SWAP;
        end
      end
      ST_SWAP: begin
        op        = OP_SWAP;
        state_nxt = ST_UP;
      end
      ST_FINAL: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result register: strobe for one cycle after the reduce cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= (state_r == ST_FINAL);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FINAL) begin
      inverse_r    <= fix_inverse;
      invertible_r <= fix_ok;
    end
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_strobe     = strobe_r;
  assign out_inverse    = inverse_r;
  assign out_invertible = invertible_r;

  // Strobe only appears once the sequencer is back in idle.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobe while busy");

  // An accepted word always starts the sequencer.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not start the sequencer");

  // Exactly one strobe cycle per result.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for more than one cycle");

  // A valid inverse is reduced below the modulus.
  a_inverse_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_invertible) |-> (out_inverse < modulus_r))
    else $error("inverse not reduced below modulus");

  // A word with no inverse reports zero.
  a_zero_when_none: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_invertible) |-> (out_inverse == '0))
    else $error("nonzero inverse with invertible low");

endmodule

/* design/modinv_datapath.sv */
// ----------------------------------------------------------------------------
// modinv_datapath: extended Euclid datapath with a shared shift/subtract unit
// Holds remainders and Bezout coefficients; one operation per cycle.
// ----------------------------------------------------------------------------
module modinv_datapath #(
  parameter int WIDTH = 31
) (
  input  logic                    clk,
  input  modinv_pkg::dp_op_t      op,
  input  logic [WIDTH-1:0]        in_value,
  input  logic [WIDTH-1:0]        modulus,
  output modinv_pkg::dp_status_t  status,
  output logic [WIDTH-1:0]        fix_inverse,
  output logic                    fix_ok
);
  import modinv_pkg::*;

  // Coefficient magnitude stays below 4*p during a shifted division.
  localparam int CW = WIDTH + 3;
  localparam int KW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0]        u_r, u_nxt;
  logic [WIDTH-1:0]        v_r, v_nxt;
  logic [WIDTH:0]          d_r, d_nxt;
  logic signed [CW-1:0]    cu_r, cu_nxt;
  logic signed [CW-1:0]    cv_r, cv_nxt;
  logic signed [CW-1:0]    cd_r, cd_nxt;
  logic [KW-1:0]           k_r, k_nxt;
  logic                    bad_r, bad_nxt;

  logic [WIDTH:0]          d_half;
  logic signed [CW-1:0]    cd_half;
  logic                    fits;
  logic signed [CW-1:0]    p_ext;
  logic signed [CW-1:0]    res_c;

  always_comb begin
    d_half  = d_r >> 1;
    cd_half = cd_r >>> 1;
    fits    = (d_half <= {1'b0, v_r});

    u_nxt   = u_r;
    v_nxt   = v_r;
    d_nxt   = d_r;
    cu_nxt  = cu_r;
    cv_nxt  = cv_r;
    cd_nxt  = cd_r;
    k_nxt   = k_r;
    bad_nxt = bad_r;

    unique case (op)
      OP_HOLD: begin
      end
      OP_LOAD: begin
        u_nxt   = in_value;
        v_nxt   = modulus;
        d_nxt   = {1'b0, in_value};
        cu_nxt  = CW'(1);
        cv_nxt  = '0;
        cd_nxt  = CW'(1);
        k_nxt   = '0;
        bad_nxt = (in_value == '0) || (modulus == '0);
      end
      OP_UP: begin
        // align divisor upward until it passes the remainder
        d_nxt  = d_r << 1;
        cd_nxt = cd_r <<< 1;
        k_nxt  = k_r + KW'(1);
      end
      OP_DOWN: begin
        // one quotient bit: subtract shifted divisor and coefficient together
        d_nxt  = d_half;
        cd_nxt = cd_half;
        k_nxt  = k_r - KW'(1);
        if (fits) begin
          v_nxt  = v_r - d_half[WIDTH-1:0];
          cv_nxt = cv_r - cd_half;
        end
      end
      OP_SWAP: begin
        v_nxt  = u_r;
        u_nxt  = v_r;
        cv_nxt = cu_r;
        cu_nxt = cv_r;
        d_nxt  = {1'b0, v_r};
        cd_nxt = cv_r;
        k_nxt  = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    u_r   <= u_nxt;
    v_r   <= v_nxt;
    d_r   <= d_nxt;
    cu_r  <= cu_nxt;
    cv_r  <= cv_nxt;
    cd_r  <= cd_nxt;
    k_r   <= k_nxt;
    bad_r <= bad_nxt;
  end

  assign status.u_zero    = (u_r == '0);
  assign status.d_above_v = (d_r > {1'b0, v_r});
  assign status.k_zero    = (k_r == '0);
  assign status.k_one     = (k_r == KW'(1));

  // Reduce the final coefficient into 0..p-1.
  always_comb begin
    p_ext = signed'(CW'(modulus));
    if (cv_r < 0) begin
      res_c = cv_r + p_ext;
    end else if (cv_r >= p_ext) begin
      res_c = cv_r - p_ext;
    end else begin
      res_c = cv_r;
    end
  end

  assign fix_ok      = !bad_r && (v_r == WIDTH'(1));
  assign fix_inverse = fix_ok ? res_c[WIDTH-1:0] : '0;

endmodule

/* verif/modinv_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modinv_checker: result checker for the modular inverse core
// Snoops the modulus register writes and every accepted word, works out the
// expected inverse and flag with exact extended Euclid, and compares each
// result word in arrival order. Reports the count of words still outstanding
// and the number of failures.
// ----------------------------------------------------------------------------
module modinv_checker #(
  parameter int WIDTH = 31
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_write_en,
  input  logic [WIDTH-1:0] cfg_modulus,
  input  logic             start,
  input  logic             busy,
  input  logic [WIDTH-1:0] in_value,
  input  logic             out_strobe,
  input  logic [WIDTH-1:0] out_inverse,
  input  logic             out_invertible,
  output int unsigned      pending_words,
  output int unsigned      mismatches
);

  typedef struct packed {
    logic [WIDTH-1:0] value;
    logic [WIDTH-1:0] inverse;
    logic             invertible;
  } inverse_t;

  inverse_t         expected_inverses[$];
  logic [WIDTH-1:0] modulus;
  int unsigned      fail_count;

  // Coefficients stay below the modulus in magnitude, so 64 bits are exact.
  function automatic inverse_t predict_inverse(logic [WIDTH-1:0] value,
                                               logic [WIDTH-1:0] p);
    longint   u, v, cu, cv, q, r, c, pl;
    inverse_t res;
    res.value      = value;
    res.inverse    = '0;
    res.invertible = 1'b0;
    if (value == '0 || p == '0) return res;
    pl = longint'(p);
    u  = longint'(value);
    v  = pl;
    cu = 1;
    cv = 0;
    while (u != 0) begin
      q  = v / u;
      r  = v % u;
      c  = cv - q * cu;
      v  = u;
      u  = r;
      cv = cu;
      cu = c;
    end
    if (v != 1) return res;
    if (cv < 0) cv = cv + pl;
    res.inverse    = WIDTH'(cv % pl);
    res.invertible = 1'b1;
    return res;
  endfunction

  always @(posedge clk) begin
    inverse_t want;
    if (!rst_n) begin
      modulus = WIDTH'(2);
      expected_inverses.delete();
    end else begin
      // check before push: a new word may be taken in the strobe cycle
      if (out_strobe) begin
        if (expected_inverses.size() == 0) begin
          $error("result word with nothing outstanding: inverse %0d invertible %0b",
                 out_inverse, out_invertible);
          fail_count++;
        end else begin
          want = expected_inverses.pop_front();
          if (out_inverse !== want.inverse) begin
            $error("inverse (value %0d): expected %0d, actual %0d",
                   want.value, want.inverse, out_inverse);
            fail_count++;
          end
          if (out_invertible !== want.invertible) begin
            $error("invertible (value %0d): expected %0b, actual %0b",
                   want.value, want.invertible, out_invertible);
            fail_count++;
          end
        end
      end
      if (start && !busy) expected_inverses.push_back(predict_inverse(in_value, modulus));
      if (cfg_write_en) modulus = cfg_modulus;
    end
    pending_words <= expected_inverses.size();
    mismatches    <= fail_count;
  end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the modular inverse core
// Walks the core through a series of moduli, from the reset value through
// the extremes of the register, sending directed corner words and then
// bursts of random words; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;

  localparam int          WIDTH      = 31;
  localparam logic [30:0] MAX_FIELD  = 31'h7fff_ffff;
  localparam int          WORDS_PER  = 50;         // random words per modulus
  localparam int          SETTLE     = 8;          // quiet cycles after each drain
  localparam longint      CYCLE_CAP  = 1_000_000;

  logic             clk          = 1'b0;
  logic             rst_n        = 1'b0;
  logic             cfg_write_en = 1'b0;
  logic [WIDTH-1:0] cfg_modulus  = '0;
  logic             start        = 1'b0;
  logic [WIDTH-1:0] in_value     = '0;
  logic             busy;
  logic             out_strobe;
  logic [WIDTH-1:0] out_inverse;
  logic             out_invertible;

  int unsigned      pending_words;
  int unsigned      mismatches;
  longint           cycle_count = 0;
  logic [WIDTH-1:0] cur_modulus = WIDTH'(2);  // mirror, used to shape values

  always #6 clk = ~clk;

  modular_inverse_core #(.WIDTH(WIDTH)) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_write_en  (cfg_write_en),
    .cfg_modulus   (cfg_modulus),
    .start         (start),
    .busy          (busy),
    .in_value      (in_value),
    .out_strobe    (out_strobe),
    .out_inverse   (out_inverse),
    .out_invertible(out_invertible)
  );

  modinv_checker #(.WIDTH(WIDTH)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_write_en  (cfg_write_en),
    .cfg_modulus   (cfg_modulus),
    .start         (start),
    .busy          (busy),
    .in_value      (in_value),
    .out_strobe    (out_strobe),
    .out_inverse   (out_inverse),
    .out_invertible(out_invertible),
    .pending_words (pending_words),
    .mismatches    (mismatches)
  );

  // Watchdog: a hung sequencer ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offer one word and hold it until the core takes it. Busy only moves at
  // the rising edge, so sampling it at the falling edge tells race-free
  // whether the next edge accepts. Return right after the accepting edge;
  // start stays high so a burst can follow without a glitch.
  task automatic send_word(input logic [WIDTH-1:0] value);
    start    <= 1'b1;
    in_value <= value;
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
  endtask

  // Drop start for a gap of length n; zero keeps the burst going.
  task automatic idle_gap(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Drain every outstanding word, then let the sequencer settle.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Change the modulus only with the core idle.
  task automatic write_modulus(input logic [WIDTH-1:0] m);
    drain();
    cfg_write_en <= 1'b1;
    cfg_modulus  <= m;
    cur_modulus   = m;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    cfg_modulus  <= WIDTH'($urandom());
    @(posedge clk);
  endtask

  // Pick a value with a bias toward the interesting corners of this modulus.
  function automatic logic [WIDTH-1:0] pick_value(input logic [WIDTH-1:0] m);
    longint k, mv;
    mv = longint'(m);
    case ($urandom_range(0, 9))
      0, 1, 2: return WIDTH'($urandom());
      3, 4, 5: return WIDTH'($urandom_range(0, 32'(m - 1)));
      6: begin
        // a multiple of the modulus: never invertible
        k = $urandom_range(1, 32'(longint'(MAX_FIELD) / mv));
        return WIDTH'(k * mv);
      end
      7: return WIDTH'($urandom_range(0, 16));
      8: begin
        k = mv + $urandom_range(0, 2) - 1;
        if (k > longint'(MAX_FIELD)) k = longint'(MAX_FIELD);
        return WIDTH'(k);
      end
      default: return MAX_FIELD - WIDTH'($urandom_range(0, 7));
    endcase
  endfunction

  // One phase of random traffic: bursts of random length, random gaps.
  task automatic random_phase(input int words);
    int left, burst;
    left = words;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      if (burst > left) burst = left;
      repeat (burst) send_word(pick_value(cur_modulus));
      left -= burst;
      // a third of the bursts run straight into the next one
      idle_gap(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20));
    end
  endtask

  logic [WIDTH-1:0] phase_moduli[11];

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset modulus of 2: zero, one, an even multiple, odd values, top value.
    send_word('0);
    send_word(WIDTH'(1));
    send_word(WIDTH'(2));
    send_word(WIDTH'(3));
    send_word(MAX_FIELD);
    idle_gap(3);

    // Largest modulus, a prime: the operand equal to it has no inverse.
    write_modulus(MAX_FIELD);
    send_word('0);
    send_word(WIDTH'(1));
    send_word(WIDTH'(2));
    send_word(MAX_FIELD - 1);
    send_word(MAX_FIELD);
    send_word(WIDTH'(12345));

    // Even modulus just below the top: even operands share a factor.
    write_modulus(MAX_FIELD - 1);
    send_word(WIDTH'(2));
    send_word(WIDTH'(3));
    send_word(MAX_FIELD);
    send_word(MAX_FIELD - 2);

    // Tiny modulus with operands well above it, multiples included.
    write_modulus(WIDTH'(3));
    send_word(WIDTH'(3));
    send_word(WIDTH'(6));
    send_word(WIDTH'(4));
    send_word(MAX_FIELD);

    // Consecutive Fibonacci numbers: the longest Euclid chain in range.
    write_modulus(WIDTH'(1836311903));
    send_word(WIDTH'(1134903170));
    send_word(WIDTH'(701408733));
    send_word(WIDTH'(1836311903));

    phase_moduli[0]  = WIDTH'(2);
    phase_moduli[1]  = MAX_FIELD;
    phase_moduli[2]  = MAX_FIELD - 1;
    phase_moduli[3]  = WIDTH'($urandom_range(3, 64));
    phase_moduli[4]  = WIDTH'(65521);
    phase_moduli[5]  = WIDTH'(1) << 30;
    phase_moduli[6]  = WIDTH'($urandom_range(2, 65535));
    phase_moduli[7]  = WIDTH'($urandom_range(2, 32'(MAX_FIELD)));
    phase_moduli[8]  = WIDTH'(1836311903);
    phase_moduli[9]  = WIDTH'($urandom_range(32'h4000_0000, 32'(MAX_FIELD)));
    phase_moduli[10] = WIDTH'($urandom_range(2, 32'(MAX_FIELD)));

    foreach (phase_moduli[i]) begin
      write_modulus(phase_moduli[i]);
      random_phase(WORDS_PER);
    end

    drain();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
